@@ hw/rtl/fixed_priority_round_robin_scheduler_core_defines.svh @@
// Assertion macros shared by the scheduler RTL.
`ifndef FIXED_PRIORITY_ROUND_ROBIN_SCHEDULER_CORE_DEFINES_SVH
`define FIXED_PRIORITY_ROUND_ROBIN_SCHEDULER_CORE_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define FPRR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define FPRR_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/fprr_pkg.sv @@
package fprr_pkg;

    localparam int NUM_TASKS  = 16;
    localparam int NUM_LEVELS = 16;

    localparam int TASK_W  = $clog2(NUM_TASKS);
    localparam int LEVEL_W = $clog2(NUM_LEVELS);
    localparam int FUNC_W  = 2;

    typedef logic [TASK_W-1:0]  task_t;
    typedef logic [LEVEL_W-1:0] level_t;
    typedef logic [FUNC_W-1:0]  func_t;

    localparam func_t FUNC_ADD      = 2'd0;
    localparam func_t FUNC_REMOVE   = 2'd1;
    localparam func_t FUNC_SCHEDULE = 2'd2;

endpackage

@@ hw/rtl/fixed_priority_round_robin_scheduler_core.sv @@
// Channel   Handshake                 Payload
// -------   -----------------------   --------------------------------------
// in        in_valid / in_ready       func, task_id, task_priority
// out       out_valid / out_ready     chosen_task, idle, error
//
// Each word passes through the request register, which feeds the ring
// update and the level priority encoder, and then through the result
// register. Sustained rate: one word per cycle while out_ready does not
// stall the result, set by the single combinational pass over the rings.
// Reset empties every ring at once (presence and level flags only).
// A stalled result holds the request in its register; in_ready drops only
// while both registers are full and out_ready is low.
`include "fixed_priority_round_robin_scheduler_core_defines.svh"

module fixed_priority_round_robin_scheduler_core
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  fprr_pkg::func_t       func,
    input  fprr_pkg::task_t       task_id,
    input  fprr_pkg::level_t      task_priority,
    output logic                  out_valid,
    input  logic                  out_ready,
    output fprr_pkg::task_t       chosen_task,
    output logic                  idle,
    output logic                  error
);
    import fprr_pkg::*;

    // Request register
    logic   req_valid_reg;
    func_t  func_reg;
    task_t  task_id_reg;
    level_t task_priority_reg;

    // Result register
    logic   out_valid_reg;
    task_t  chosen_task_reg;
    logic   idle_reg;
    logic   error_reg;

    // Ring tables: links, priorities and heads need no reset, since they are
    // read only for present tasks and non-empty levels.
    task_t                 next_link_reg       [NUM_TASKS];
    task_t                 prev_link_reg       [NUM_TASKS];
    level_t                stored_priority_reg [NUM_TASKS];
    task_t                 level_head_reg      [NUM_LEVELS];
    logic [NUM_TASKS-1:0]  task_present_reg;
    logic [NUM_LEVELS-1:0] level_nonempty_reg;

    task_t                 next_link_next       [NUM_TASKS];
    task_t                 prev_link_next       [NUM_TASKS];
    level_t                stored_priority_next [NUM_TASKS];
    task_t                 level_head_next      [NUM_LEVELS];
    logic [NUM_TASKS-1:0]  task_present_next;
    logic [NUM_LEVELS-1:0] level_nonempty_next;

    logic   advance;
    task_t  chosen_c;
    logic   idle_c;
    logic   error_c;

    // Priority encoder over non-empty levels, lowest index wins
    level_t sel_level;
    logic   any_level;

    // Working values of the update pass
    task_t  head_p;
    task_t  tail_p;
    level_t rem_level;
    task_t  rem_next;
    task_t  rem_prev;

    // Advance the request into the result register when that slot frees up.
    assign advance  = req_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !req_valid_reg || advance;

    always_comb
    begin
        sel_level = '0;
        any_level = 1'b0;
        for (int lv = NUM_LEVELS - 1; lv >= 0; lv--)
        begin
            if (level_nonempty_reg[lv])
            begin
                sel_level = LEVEL_W'(lv);
                any_level = 1'b1;
            end
        end
    end

    always_comb
    begin
        next_link_next       = next_link_reg;
        prev_link_next       = prev_link_reg;
        stored_priority_next = stored_priority_reg;
        level_head_next      = level_head_reg;
        task_present_next    = task_present_reg;
        level_nonempty_next  = level_nonempty_reg;

        chosen_c = '0;
        idle_c   = 1'b0;
        error_c  = 1'b0;

        head_p    = level_head_reg[task_priority_reg];
        tail_p    = prev_link_reg[head_p];
        rem_level = stored_priority_reg[task_id_reg];
        rem_next  = next_link_reg[task_id_reg];
        rem_prev  = prev_link_reg[task_id_reg];

        case (func_reg)
            FUNC_ADD:
            begin
                if (task_present_reg[task_id_reg])
                begin
                    error_c = 1'b1;
                end
                else
                begin
                    if (level_nonempty_reg[task_priority_reg])
                    begin
                        // Append just before the head.
                        next_link_next[task_id_reg] = head_p;
                        prev_link_next[task_id_reg] = tail_p;
                        next_link_next[tail_p]      = task_id_reg;
                        prev_link_next[head_p]      = task_id_reg;
                    end
                    else
                    begin
                        next_link_next[task_id_reg]            = task_id_reg;
                        prev_link_next[task_id_reg]            = task_id_reg;
                        level_head_next[task_priority_reg]     = task_id_reg;
                        level_nonempty_next[task_priority_reg] = 1'b1;
                    end
                    stored_priority_next[task_id_reg] = task_priority_reg;
                    task_present_next[task_id_reg]    = 1'b1;
                end
            end
            FUNC_REMOVE:
            begin
                if (!task_present_reg[task_id_reg])
                begin
                    error_c = 1'b1;
                end
                else
                begin
                    task_present_next[task_id_reg] = 1'b0;
                    if (level_head_reg[rem_level] == task_id_reg && rem_next == task_id_reg)
                    begin
                        // Last task of its ring: drop the level.
                        level_nonempty_next[rem_level] = 1'b0;
                    end
                    else
                    begin
                        if (level_head_reg[rem_level] == task_id_reg)
                        begin
                            level_head_next[rem_level] = rem_next;
                        end
                        next_link_next[rem_prev] = rem_next;
                        prev_link_next[rem_next] = rem_prev;
                    end
                end
            end
            FUNC_SCHEDULE:
            begin
                if (any_level)
                begin
                    chosen_c                   = level_head_reg[sel_level];
                    level_head_next[sel_level] = next_link_reg[level_head_reg[sel_level]];
                end
                else
                begin
                    idle_c = 1'b1;
                end
            end
            default:
            begin
                chosen_c = '0;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg      <= 1'b0;
            out_valid_reg      <= 1'b0;
            task_present_reg   <= '0;
            level_nonempty_reg <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                req_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg      <= 1'b1;
                task_present_reg   <= task_present_next;
                level_nonempty_reg <= level_nonempty_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload and ring tables
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            func_reg          <= func;
            task_id_reg       <= task_id;
            task_priority_reg <= task_priority;
        end
        if (advance)
        begin
            chosen_task_reg     <= chosen_c;
            idle_reg            <= idle_c;
            error_reg           <= error_c;
            next_link_reg       <= next_link_next;
            prev_link_reg       <= prev_link_next;
            stored_priority_reg <= stored_priority_next;
            level_head_reg      <= level_head_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign chosen_task = chosen_task_reg;
    assign idle        = idle_reg;
    assign error       = error_reg;

    `FPRR_ASSERT(a_idle_clean, out_valid_reg |-> !(idle_reg && (chosen_task_reg != '0 || error_reg)), "idle result carries a task or error")
    `FPRR_ASSERT_ALWAYS(a_empty_levels, (task_present_reg == '0) |-> (level_nonempty_reg == '0), "level marked non-empty with no task present")
    `FPRR_ASSERT(a_add_sets_present, (advance && func_reg == FUNC_ADD && !error_c) |=> task_present_reg[$past(task_id_reg)], "accepted add left task absent")
    `FPRR_ASSERT(a_stall_cause, !in_ready |-> (req_valid_reg && out_valid_reg && !out_ready), "input stalled without a full pipeline")

endmodule
